/* rtl/core/tlik_pkg.sv */
// ----------------------------------------------------------------------------
// tlik_pkg
// Shared widths, angle constants, the arc tangent table and register codes
// of the two-link arm inverse kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlik_pkg;

  localparam int CW      = 20;
  localparam int LW      = 18;
  localparam int NUMW    = 42;
  localparam int DENW    = 40;
  localparam int ACW     = 31;
  localparam int SHW     = 4;
  localparam int ZW      = 26;
  localparam int AW      = 28;
  localparam int FRAC    = 16;
  localparam int TAB_LEN = 24;

  localparam int DEG90  = 5898240;
  localparam int DEG180 = 11796480;
  localparam int DEG360 = 23592960;

  localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  localparam logic [2:0] CFG_UPPER   = 3'd0;
  localparam logic [2:0] CFG_LOWER   = 3'd1;
  localparam logic [2:0] CFG_MIN     = 3'd2;
  localparam logic [2:0] CFG_MAX     = 3'd3;
  localparam logic [2:0] CFG_FLOOR_X = 3'd4;
  localparam logic [2:0] CFG_FLOOR_Z = 3'd5;

  localparam logic [LW-1:0]        RST_UPPER   = 18'd1600;
  localparam logic [LW-1:0]        RST_LOWER   = 18'd1600;
  localparam logic [CW-1:0]        RST_MIN     = 20'd160;
  localparam logic [CW-1:0]        RST_MAX     = 20'd3040;
  localparam logic signed [CW-1:0] RST_FLOOR_X = 20'sd0;
  localparam logic signed [CW-1:0] RST_FLOOR_Z = 20'sd0;

endpackage

`default_nettype wire

/* rtl/core/tlik_isqrt.sv */
// ----------------------------------------------------------------------------
// tlik_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
`default_nettype none

module tlik_isqrt #(
  parameter int WIDTH = 40,
  parameter int SW    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [WIDTH-1:0]     value_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic [WIDTH/2-1:0]   root_o,
  output logic [SW-1:0]        side_o
);

  localparam int RW   = WIDTH / 2;
  localparam int REMW = RW + 2;

  logic [RW-1:0]    vld_q;
  logic [WIDTH-1:0] val_q  [RW];
  logic [RW-1:0]    root_q [RW];
  logic [REMW-1:0]  rem_q  [RW];
  logic [SW-1:0]    side_q [RW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [WIDTH-1:0] v_in;
    logic [RW-1:0]    r_in;
    logic [REMW-1:0]  m_in;
    logic [SW-1:0]    s_in;
    logic [REMW-1:0]  trial;
    logic [REMW-1:0]  cand;

    if (k == 0) begin : g_first
      assign v_in = value_i;
      assign r_in = '0;
      assign m_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = val_q[k-1];
      assign r_in = root_q[k-1];
      assign m_in = rem_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign trial = {m_in[REMW-3:0], v_in[WIDTH-1 -: 2]};
    assign cand  = {r_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (trial >= cand) begin
        rem_q[k]  <= trial - cand;
        root_q[k] <= {r_in[RW-2:0], 1'b1};
      end else begin
        rem_q[k]  <= trial;
        root_q[k] <= {r_in[RW-2:0], 1'b0};
      end
      val_q[k]  <= v_in << 2;
      side_q[k] <= s_in;
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

/* rtl/core/tlik_cordic.sv */
// ----------------------------------------------------------------------------
// tlik_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in degrees with 16 fraction
// bits: one quadrant pre-rotation stage, then one micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tlik_cordic #(
  parameter int IN_W   = 21,
  parameter int STAGES = 16,
  parameter int SW     = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic signed [IN_W-1:0]        y_i,
  input  logic signed [IN_W-1:0]        x_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic signed [tlik_pkg::ZW-1:0] angle_o,
  output logic [SW-1:0]                 side_o
);

  localparam int XW = IN_W + 2;

  logic [STAGES:0]              vld_q;
  logic signed [XW-1:0]         xv_q   [STAGES+1];
  logic signed [XW-1:0]         yv_q   [STAGES+1];
  logic signed [tlik_pkg::ZW-1:0] z_q  [STAGES+1];
  logic [STAGES:0]              zero_q;
  logic [SW-1:0]                side_q [STAGES+1];

  logic signed [XW-1:0]         xe, ye, x0_d, y0_d;
  logic signed [tlik_pkg::ZW-1:0] z0_d;

  assign xe = XW'(x_i);
  assign ye = XW'(y_i);

  always_comb begin
    x0_d = xe;
    y0_d = ye;
    z0_d = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_d = ye;
        y0_d = -xe;
        z0_d = tlik_pkg::ZW'(tlik_pkg::DEG90);
      end else begin
        x0_d = -ye;
        y0_d = xe;
        z0_d = -(tlik_pkg::ZW'(tlik_pkg::DEG90));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    xv_q[0]   <= x0_d;
    yv_q[0]   <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    side_q[0] <= side_i;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    always_ff @(posedge clk_i) begin
      if (yv_q[i] >= 0) begin
        xv_q[i+1] <= xv_q[i] + (yv_q[i] >>> i);
        yv_q[i+1] <= yv_q[i] - (xv_q[i] >>> i);
        z_q[i+1]  <= z_q[i] + tlik_pkg::ATAN_TAB[i];
      end else begin
        xv_q[i+1] <= xv_q[i] - (yv_q[i] >>> i);
        yv_q[i+1] <= yv_q[i] + (xv_q[i] >>> i);
        z_q[i+1]  <= z_q[i] - tlik_pkg::ATAN_TAB[i];
      end
      zero_q[i+1] <= zero_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign valid_o = vld_q[STAGES];
  assign angle_o = zero_q[STAGES] ? '0 : z_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

`default_nettype wire

/* rtl/core/tlik_acos.sv */
// ----------------------------------------------------------------------------
// tlik_acos
// Pipelined arc cosine of num/den as atan2(sqrt(den^2 - num^2), num), with
// range checks, operand narrowing, squaring, a root and a CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module tlik_acos #(
  parameter int STAGES = 16,
  parameter int SW     = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic signed [tlik_pkg::NUMW-1:0] num_i,
  input  logic [tlik_pkg::DENW-1:0]       den_i,
  input  logic [SW-1:0]                   side_i,
  output logic                            valid_o,
  output logic signed [tlik_pkg::ZW-1:0]  angle_o,
  output logic [SW-1:0]                   side_o
);

  localparam int NUMW = tlik_pkg::NUMW;
  localparam int DENW = tlik_pkg::DENW;
  localparam int ACW  = tlik_pkg::ACW;
  localparam int SHW  = tlik_pkg::SHW;
  localparam int QSW  = SW + 2 + ACW;
  localparam int CSW  = SW + 2;

  logic [4:0]          vld_q;
  logic                neg1_q, neg2_q, neg3_q, neg4_q, neg5_q;
  logic                spec2_q, spec3_q, spec4_q, spec5_q;
  logic [NUMW-1:0]     mag1_q, mag2_q;
  logic [DENW-1:0]     den1_q, den2_q;
  logic [SHW-1:0]      sh_d, sh2_q;
  logic [ACW-1:0]      dn3_q, mg3_q, mg4_q, mg5_q;
  logic [2*ACW-1:0]    dd4_q, mm4_q, diff5_q;
  logic [SW-1:0]       side1_q, side2_q, side3_q, side4_q, side5_q;

  logic                q_valid;
  logic [ACW-1:0]      q_root;
  logic [QSW-1:0]      q_side;
  logic [SW-1:0]       q_s;
  logic                q_neg, q_spec;
  logic [ACW-1:0]      q_mag;
  logic signed [ACW:0] c_x, c_y;

  logic                        c_valid;
  logic signed [tlik_pkg::ZW-1:0] c_angle;
  logic [CSW-1:0]              c_side;
  logic [SW-1:0]               c_s;
  logic                        c_neg, c_spec;

  always_comb begin
    sh_d = '0;
    for (int k = ACW; k < DENW; k++) begin
      if (den1_q[k]) begin
        sh_d = SHW'(k - ACW + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    neg1_q  <= num_i[NUMW-1];
    mag1_q  <= num_i[NUMW-1] ? NUMW'(-num_i) : NUMW'(num_i);
    den1_q  <= den_i;
    side1_q <= side_i;

    neg2_q  <= neg1_q;
    spec2_q <= (den1_q == '0) || (mag1_q >= NUMW'(den1_q));
    mag2_q  <= mag1_q;
    den2_q  <= den1_q;
    sh2_q   <= sh_d;
    side2_q <= side1_q;

    neg3_q  <= neg2_q;
    spec3_q <= spec2_q;
    dn3_q   <= ACW'(den2_q >> sh2_q);
    mg3_q   <= ACW'(mag2_q >> sh2_q);
    side3_q <= side2_q;

    neg4_q  <= neg3_q;
    spec4_q <= spec3_q;
    mg4_q   <= mg3_q;
    dd4_q   <= dn3_q * dn3_q;
    mm4_q   <= mg3_q * mg3_q;
    side4_q <= side3_q;

    neg5_q  <= neg4_q;
    spec5_q <= spec4_q;
    mg5_q   <= mg4_q;
    diff5_q <= dd4_q - mm4_q;
    side5_q <= side4_q;
  end

  tlik_isqrt #(
    .WIDTH (2 * ACW),
    .SW    (QSW)
  ) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[4]),
    .value_i (diff5_q),
    .side_i  ({side5_q, neg5_q, spec5_q, mg5_q}),
    .valid_o (q_valid),
    .root_o  (q_root),
    .side_o  (q_side)
  );

  assign {q_s, q_neg, q_spec, q_mag} = q_side;
  assign c_y = {1'b0, q_root};
  assign c_x = q_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

  tlik_cordic #(
    .IN_W   (ACW + 1),
    .STAGES (STAGES),
    .SW     (CSW)
  ) u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .y_i     (c_y),
    .x_i     (c_x),
    .side_i  ({q_s, q_neg, q_spec}),
    .valid_o (c_valid),
    .angle_o (c_angle),
    .side_o  (c_side)
  );

  assign {c_s, c_neg, c_spec} = c_side;

  assign valid_o = c_valid;
  assign side_o  = c_s;
  assign angle_o = !c_spec ? c_angle :
                   (c_neg ? tlik_pkg::ZW'(tlik_pkg::DEG180) : '0);

endmodule

`default_nettype wire

/* rtl/core/two_link_arm_inverse_kinematics_top.sv */
// ----------------------------------------------------------------------------
// two_link_arm_inverse_kinematics_top
// Joint angles for a two-link arm on a rotating base from a target point.
// The path from start to done runs through the reach root (20 stages), the
// arc cosine root (31 stages) and two CORDIC chains.
// Throughput: one item per cycle; busy is never raised.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module two_link_arm_inverse_kinematics_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [19:0] target_x_i,
  input  logic signed [19:0] target_y_i,
  input  logic signed [19:0] target_z_i,
  output logic               done_o,
  output logic signed [15:0] base_angle_o,
  output logic signed [15:0] shoulder_angle_o,
  output logic [13:0]        elbow_angle_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i
);

  localparam int CW   = tlik_pkg::CW;
  localparam int LW   = tlik_pkg::LW;
  localparam int NUMW = tlik_pkg::NUMW;
  localparam int DENW = tlik_pkg::DENW;
  localparam int ZW   = tlik_pkg::ZW;
  localparam int AW   = tlik_pkg::AW;
  localparam int FRAC = tlik_pkg::FRAC;
  localparam int HALF = 1 << (FRAC - 1);
  localparam logic signed [15:0] ANG_LO = -16'sd11520;
  localparam logic signed [15:0] ANG_HI = 16'sd23040;
  localparam logic signed [15:0] ELB_LO = 16'sd0;
  localparam logic signed [15:0] ELB_HI = 16'sd11520;

  function automatic logic signed [15:0] round_deg(input logic signed [AW-1:0] v,
                                                   input logic signed [15:0] lo,
                                                   input logic signed [15:0] hi);
    logic signed [AW-1:0] s;
    logic signed [15:0]   r;
    s = (v + AW'(HALF)) >>> FRAC;
    r = 16'(s);
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  logic [LW-1:0]        upper_q, lower_q;
  logic [CW-1:0]        min_q, max_q;
  logic signed [CW-1:0] floor_x_q, floor_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= tlik_pkg::RST_UPPER;
      lower_q   <= tlik_pkg::RST_LOWER;
      min_q     <= tlik_pkg::RST_MIN;
      max_q     <= tlik_pkg::RST_MAX;
      floor_x_q <= tlik_pkg::RST_FLOOR_X;
      floor_z_q <= tlik_pkg::RST_FLOOR_Z;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlik_pkg::CFG_UPPER:   upper_q   <= cfg_data_i[LW-1:0];
        tlik_pkg::CFG_LOWER:   lower_q   <= cfg_data_i[LW-1:0];
        tlik_pkg::CFG_MIN:     min_q     <= cfg_data_i;
        tlik_pkg::CFG_MAX:     max_q     <= cfg_data_i;
        tlik_pkg::CFG_FLOOR_X: floor_x_q <= cfg_data_i;
        tlik_pkg::CFG_FLOOR_Z: floor_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  logic                 v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  logic signed [CW-1:0] x0_q, y0_q, z0_q, x1_q, y1_q, z1_q, x2_q, y2_q, z2_q;
  logic [2*CW-2:0]      xx1_q, yy1_q, zz1_q;
  logic [2*CW-1:0]      sh2_q, sr2_q;
  logic signed [2*CW-1:0] xx_w, yy_w, zz_w;
  logic                 q_h_valid, q_r_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= q_h_valid && q_r_valid;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign xx_w = x0_q * x0_q;
  assign yy_w = y0_q * y0_q;
  assign zz_w = z0_q * z0_q;

  always_ff @(posedge clk_i) begin
    x0_q  <= (target_x_i < floor_x_q) ? floor_x_q : target_x_i;
    y0_q  <= target_y_i;
    z0_q  <= (target_z_i < floor_z_q) ? floor_z_q : target_z_i;

    xx1_q <= xx_w[2*CW-2:0];
    yy1_q <= yy_w[2*CW-2:0];
    zz1_q <= zz_w[2*CW-2:0];
    x1_q  <= x0_q;
    y1_q  <= y0_q;
    z1_q  <= z0_q;

    sh2_q <= {1'b0, xx1_q} + {1'b0, yy1_q};
    sr2_q <= {1'b0, xx1_q} + {1'b0, yy1_q} + {1'b0, zz1_q};
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    z2_q  <= z1_q;
  end

  logic [CW-1:0]   q_hxy, q_reach;
  logic [2*CW-1:0] q_h_side;
  logic [CW-1:0]   q_r_side;

  tlik_isqrt #(
    .WIDTH (2 * CW),
    .SW    (2 * CW)
  ) u_hroot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .value_i (sh2_q),
    .side_i  ({x2_q, y2_q}),
    .valid_o (q_h_valid),
    .root_o  (q_hxy),
    .side_o  (q_h_side)
  );

  tlik_isqrt #(
    .WIDTH (2 * CW),
    .SW    (CW)
  ) u_rroot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .value_i (sr2_q),
    .side_i  (z2_q),
    .valid_o (q_r_valid),
    .root_o  (q_reach),
    .side_o  (q_r_side)
  );

  logic signed [CW-1:0] qx, qy;
  logic signed [CW:0]   h_d;
  logic [CW-1:0]        c_d;

  assign {qx, qy} = q_h_side;
  assign h_d = (qx > 0) ? $signed({1'b0, q_hxy}) : -$signed({1'b0, q_hxy});

  always_comb begin
    if (q_reach < min_q) begin
      c_d = min_q;
    end else if (q_reach > max_q) begin
      c_d = max_q;
    end else begin
      c_d = q_reach;
    end
  end

  logic [CW-1:0]        c3_q;
  logic signed [CW-1:0] x3_q, y3_q, z3_q, x4_q, y4_q, z4_q, x5_q, y5_q, z5_q;
  logic signed [CW:0]   h3_q, h4_q, h5_q;
  logic [2*LW-1:0]      aa4_q, bb4_q, ab4_q;
  logic [2*CW-1:0]      cc4_q;
  logic [LW+CW-1:0]     bc4_q;
  logic signed [NUMW-1:0] nume5_q, nums5_q;
  logic [DENW-1:0]      dene5_q, dens5_q;

  always_ff @(posedge clk_i) begin
    c3_q  <= c_d;
    h3_q  <= h_d;
    x3_q  <= qx;
    y3_q  <= qy;
    z3_q  <= q_r_side;

    aa4_q <= lower_q * lower_q;
    bb4_q <= upper_q * upper_q;
    ab4_q <= lower_q * upper_q;
    cc4_q <= c3_q * c3_q;
    bc4_q <= upper_q * c3_q;
    x4_q  <= x3_q;
    y4_q  <= y3_q;
    z4_q  <= z3_q;
    h4_q  <= h3_q;

    nume5_q <= $signed(NUMW'(aa4_q)) + $signed(NUMW'(bb4_q)) - $signed(NUMW'(cc4_q));
    nums5_q <= $signed(NUMW'(bb4_q)) + $signed(NUMW'(cc4_q)) - $signed(NUMW'(aa4_q));
    dene5_q <= DENW'({ab4_q, 1'b0});
    dens5_q <= DENW'({bc4_q, 1'b0});
    x5_q  <= x4_q;
    y5_q  <= y4_q;
    z5_q  <= z4_q;
    h5_q  <= h4_q;
  end

  logic                 e_valid, s_valid;
  logic signed [ZW-1:0] elbow_w, xang_w;
  logic [2*CW-1:0]      e_side;
  logic [2*CW:0]        s_side;
  logic signed [CW-1:0] ex, ey, sz;
  logic signed [CW:0]   sh;
  logic signed [CW:0]   ny, bx, ez;

  tlik_acos #(
    .STAGES (CORDIC_STAGES),
    .SW     (2 * CW)
  ) u_elbow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (nume5_q),
    .den_i   (dene5_q),
    .side_i  ({x5_q, y5_q}),
    .valid_o (e_valid),
    .angle_o (elbow_w),
    .side_o  (e_side)
  );

  tlik_acos #(
    .STAGES (CORDIC_STAGES),
    .SW     (2 * CW + 1)
  ) u_shoulder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .num_i   (nums5_q),
    .den_i   (dens5_q),
    .side_i  ({z5_q, h5_q}),
    .valid_o (s_valid),
    .angle_o (xang_w),
    .side_o  (s_side)
  );

  assign {ex, ey} = e_side;
  assign {sz, sh} = s_side;
  assign ny = -(CW + 1)'(ey);
  assign bx = (CW + 1)'(ex);
  assign ez = (CW + 1)'(sz);

  logic                 b_valid, y_valid;
  logic signed [ZW-1:0] base_w, elev_w;
  logic                 b_side;
  logic [2*ZW-1:0]      y_side;
  logic signed [ZW-1:0] elbow_d, xang_d;

  tlik_cordic #(
    .IN_W   (CW + 1),
    .STAGES (CORDIC_STAGES),
    .SW     (1)
  ) u_base (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid && s_valid),
    .y_i     (ny),
    .x_i     (bx),
    .side_i  (ex[CW-1]),
    .valid_o (b_valid),
    .angle_o (base_w),
    .side_o  (b_side)
  );

  tlik_cordic #(
    .IN_W   (CW + 1),
    .STAGES (CORDIC_STAGES),
    .SW     (2 * ZW)
  ) u_elev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid && s_valid),
    .y_i     (ez),
    .x_i     (sh),
    .side_i  ({elbow_w, xang_w}),
    .valid_o (y_valid),
    .angle_o (elev_w),
    .side_o  (y_side)
  );

  assign {elbow_d, xang_d} = y_side;

  logic                 p1_q, p2_q, done_q;
  logic                 xneg1_q;
  logic signed [AW-1:0] base1_q, sh1_q, el1_q, base2_q, sh2a_q, el2_q;
  logic signed [15:0]   base_q, shoulder_q, elbow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q   <= 1'b0;
      p2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      p1_q   <= b_valid && y_valid;
      p2_q   <= p1_q;
      done_q <= p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    base1_q <= AW'(base_w) + AW'(tlik_pkg::DEG90);
    sh1_q   <= AW'(xang_d) + AW'(elev_w);
    el1_q   <= AW'(elbow_d);
    xneg1_q <= b_side;

    base2_q <= ((base1_q < 0) ? base1_q + AW'(tlik_pkg::DEG360) : base1_q)
             - (xneg1_q ? AW'(tlik_pkg::DEG180) : AW'(0));
    sh2a_q  <= sh1_q;
    el2_q   <= el1_q;

    base_q     <= round_deg(base2_q, ANG_LO, ANG_HI);
    shoulder_q <= round_deg(sh2a_q, ANG_LO, ANG_HI);
    elbow_q    <= round_deg(el2_q, ELB_LO, ELB_HI);
  end

  assign done_o           = done_q;
  assign base_angle_o     = base_q;
  assign shoulder_angle_o = shoulder_q;
  assign elbow_angle_o    = elbow_q[13:0];

endmodule

`default_nettype wire

/* test/tlik_checker.sv */
// ----------------------------------------------------------------------------
// Joint angle checker
// Watches the target, result and register ports of the inverse kinematics
// block. It predicts the joint angles of every accepted target and compares
// them in order with the results that come out.
// ----------------------------------------------------------------------------
module tlik_checker
  import tlik_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [19:0] target_x_i,
  input  logic signed [19:0] target_y_i,
  input  logic signed [19:0] target_z_i,
  input  logic               done_i,
  input  logic signed [15:0] base_angle_i,
  input  logic signed [15:0] shoulder_angle_i,
  input  logic [13:0]        elbow_angle_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [19:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] base;
    logic signed [15:0] shoulder;
    logic [13:0]        elbow;
  } joint_angles_t;

  localparam longint ONE_DEG = 65536;
  localparam longint ARC_TAN [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  joint_angles_t      angles_q[$];
  logic [LW-1:0]      upper_len;
  logic [LW-1:0]      lower_len;
  logic [CW-1:0]      reach_lo;
  logic [CW-1:0]      reach_hi;
  logic signed [CW-1:0] clamp_x;
  logic signed [CW-1:0] clamp_z;
  int                 errors;

  assign errors_o  = errors;
  assign pending_o = angles_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint ang;
    longint t;
    longint dx;
    longint dy;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv;
        yv = -t;
        ang = 90 * ONE_DEG;
      end else begin
        xv = -yv;
        yv = t;
        ang = -90 * ONE_DEG;
      end
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx;
        yv -= dy;
        ang += ARC_TAN[i];
      end else begin
        xv -= dx;
        yv += dy;
        ang -= ARC_TAN[i];
      end
    end
    return ang;
  endfunction

  function automatic longint cos_angle(longint num, longint unsigned den);
    bit              neg;
    longint unsigned mag;
    longint unsigned t;
    neg = num < 0;
    mag = neg ? longint'(-num) : num;
    if (den == 0 || mag >= den) return neg ? 180 * ONE_DEG : 0;
    while (den >= (64'd1 << 31)) begin
      den = den >> 1;
      mag = mag >> 1;
    end
    t = int_sqrt(den * den - mag * mag);
    return vector_angle(longint'(t), neg ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic longint to_output(longint v, longint lo, longint hi);
    longint r;
    r = ((v + 4096 * ONE_DEG + ONE_DEG / 2) >>> 16) - 4096;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic joint_angles_t solve_joints(longint x, longint y, longint z);
    joint_angles_t   res;
    longint unsigned horiz;
    longint unsigned reach;
    longint          a;
    longint          b;
    longint          c;
    longint          h;
    longint          elbow;
    longint          shoulder;
    longint          base;
    if (x < longint'(clamp_x)) x = clamp_x;
    if (z < longint'(clamp_z)) z = clamp_z;
    horiz = int_sqrt(x * x + y * y);
    reach = int_sqrt(x * x + y * y + z * z);
    if (reach < reach_lo) reach = reach_lo;
    else if (reach > reach_hi) reach = reach_hi;
    a = lower_len;
    b = upper_len;
    c = reach;
    elbow = cos_angle(a * a + b * b - c * c, 2 * a * b);
    h = (x > 0) ? longint'(horiz) : -longint'(horiz);
    shoulder = cos_angle(b * b + c * c - a * a, 2 * b * c) + vector_angle(z, h);
    base = vector_angle(-y, x) + 90 * ONE_DEG;
    if (base < 0) base += 360 * ONE_DEG;
    if (x < 0) base -= 180 * ONE_DEG;
    res.base     = 16'(to_output(base, -11520, 23040));
    res.shoulder = 16'(to_output(shoulder, -11520, 23040));
    res.elbow    = 14'(to_output(elbow, 0, 11520));
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    joint_angles_t want;
    if (!rst_ni) begin
      upper_len <= RST_UPPER;
      lower_len <= RST_LOWER;
      reach_lo  <= RST_MIN;
      reach_hi  <= RST_MAX;
      clamp_x   <= RST_FLOOR_X;
      clamp_z   <= RST_FLOOR_Z;
      errors    <= 0;
      angles_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_UPPER:   upper_len <= cfg_data_i[LW-1:0];
          CFG_LOWER:   lower_len <= cfg_data_i[LW-1:0];
          CFG_MIN:     reach_lo  <= cfg_data_i;
          CFG_MAX:     reach_hi  <= cfg_data_i;
          CFG_FLOOR_X: clamp_x   <= cfg_data_i;
          CFG_FLOOR_Z: clamp_z   <= cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        angles_q.push_back(solve_joints(target_x_i, target_y_i, target_z_i));
      end
      if (done_i) begin
        if (angles_q.size() == 0) begin
          if (errors < 10) $display("unexpected result at %0t", $realtime);
          errors <= errors + 1;
        end else begin
          want = angles_q.pop_front();
          if (want.base !== base_angle_i || want.shoulder !== shoulder_angle_i ||
              want.elbow !== elbow_angle_i) begin
            if (errors < 10) begin
              $display("mismatch at %0t: expected %0d %0d %0d, got %0d %0d %0d",
                       $realtime, want.base, want.shoulder, want.elbow,
                       base_angle_i, shoulder_angle_i, elbow_angle_i);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Inverse kinematics testbench
// Drives directed and random targets through the block under several
// register settings with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tlik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN = 130;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic signed [19:0] target_x_i = '0;
  logic signed [19:0] target_y_i = '0;
  logic signed [19:0] target_z_i = '0;
  logic               done_o;
  logic signed [15:0] base_angle_o;
  logic signed [15:0] shoulder_angle_o;
  logic [13:0]        elbow_angle_o;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_idx_i = '0;
  logic [19:0]        cfg_data_i = '0;
  int                 errors;
  int                 pending;
  bit                 no_gaps;

  always #2 clk_i = ~clk_i;

  two_link_arm_inverse_kinematics_top i_dut (.*);

  tlik_checker i_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .target_x_i, .target_y_i, .target_z_i,
    .done_i(done_o), .base_angle_i(base_angle_o), .shoulder_angle_i(shoulder_angle_o),
    .elbow_angle_i(elbow_angle_o), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  task automatic send_target(logic [19:0] x, logic [19:0] y, logic [19:0] z);
    int  gap;
    bit  taken;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0 && start_i) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else if (gap > 0) begin
      repeat (gap - 1) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    target_x_i <= x;
    target_y_i <= y;
    target_z_i <= z;
    do begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    if (start_i) start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_regs(logic [19:0] up, logic [19:0] lo, logic [19:0] rmin,
                           logic [19:0] rmax, logic [19:0] fx, logic [19:0] fz);
    drain();
    write_reg(CFG_UPPER, up);
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_MIN, rmin);
    write_reg(CFG_MAX, rmax);
    write_reg(CFG_FLOOR_X, fx);
    write_reg(CFG_FLOOR_Z, fz);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [19:0] coord();
    case ($urandom_range(0, 9))
      0, 1:    return 20'($urandom);
      2:       return $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
      3:       return 20'($signed($urandom_range(0, 64)) - 32);
      default: return 20'($signed($urandom_range(0, 8000)) - 4000);
    endcase
  endfunction

  task automatic random_targets(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_target(coord(), coord(), coord());
    end
    no_gaps = 0;
  endtask

  initial begin
    #(4 * 2000000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    no_gaps = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_target(0, 0, 0);
    send_target(20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
    send_target(20'h80000, 20'h80000, 20'h80000);
    send_target(1600, 0, 0);
    send_target(3200, 0, 0);
    send_target(-1600, 0, 800);
    send_target(0, 1600, 0);
    send_target(0, -1600, 0);
    send_target(-800, -800, 800);
    send_target(800, 800, -800);
    send_target(1, 0, 1);
    send_target(-1, 1, 0);
    send_target(2000, -1000, 1500);
    send_target(0, 0, 3040);
    load_regs(20'd1, 20'd1, 20'd0, 20'hFFFFF, 20'h80000, 20'h80000);
    send_target(0, 0, 0);
    send_target(20'h7FFFF, 20'h80000, 20'h7FFFF);
    send_target(-5, 3, -7);
    load_regs(20'h3FFFF, 20'h3FFFF, 20'hFFFFF, 20'd0, 20'h7FFFF, 20'h7FFFF);
    send_target(100, 100, 100);
    send_target(20'h80000, 20'h7FFFF, 20'h80000);
    load_regs(20'd1600, 20'd1600, 20'd160, 20'd3040, 20'd0, 20'd0);
    random_targets(200);
    load_regs(20'd1, 20'h3FFFF, 20'd0, 20'hFFFFF, 20'h80000, 20'h80000);
    random_targets(120);
    load_regs(20'd3000, 20'd1000, 20'd3000, 20'd500, -20'sd200, 20'sd100);
    random_targets(120);
    load_regs(20'h3FFFF, 20'd1, 20'hFFFFF, 20'hFFFFF, 20'h7FFFF, 20'h80000);
    random_targets(80);
    for (int p = 0; p < 4; p++) begin
      load_regs($urandom_range(1, 4000), $urandom_range(1, 4000), $urandom_range(0, 800),
                $urandom_range(1000, 9000), 20'($signed($urandom_range(0, 2000)) - 1000),
                20'($signed($urandom_range(0, 2000)) - 1000));
      random_targets(95);
    end
    drain();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
